@@ rtl/ip_address_text_classifier_unit_macros.svh @@
// Assertion macros for the IP address text classifier.
// Included by the RTL files that carry assertions; no other dependencies.
`ifndef IP_ADDRESS_TEXT_CLASSIFIER_UNIT_MACROS_SVH
`define IP_ADDRESS_TEXT_CLASSIFIER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked outside reset.
`define IPATC_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ipatc assertion failed");
// Next-cycle implication, checked outside reset.
`define IPATC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ipatc assertion failed");
`else
`define IPATC_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define IPATC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/ipatc_pkg.sv @@
// Shared constants for the IP address text classifier.
// No dependencies; used by ip_address_text_classifier_unit.
`default_nettype none
package ipatc_pkg;

  // Result codes carried in address_kind.
  localparam logic [1:0] KIND_NEITHER = 2'd0;
  localparam logic [1:0] KIND_V4      = 2'd1;
  localparam logic [1:0] KIND_V6      = 2'd2;

  // Character codes.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_F = 8'h66;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_DOT     = 8'h2E;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;

  // Saturation points and limits.
  localparam logic [8:0] VALUE_SAT    = 9'd256;
  localparam logic [8:0] VALUE_MAX    = 9'd255;
  localparam logic [2:0] COUNT_SAT    = 3'd7;
  localparam logic [3:0] COLON_SAT    = 4'd15;
  localparam logic [2:0] V4_DOTS      = 3'd3;
  localparam logic [3:0] V6_COLONS    = 4'd7;
  localparam logic [2:0] V6_MAX_CHARS = 3'd4;

endpackage
`default_nettype wire

@@ rtl/ip_address_text_classifier_unit.sv @@
// Top level of the IP address text classifier: per-character state update and result register.
// Depends on ipatc_pkg and ip_address_text_classifier_unit_macros.svh.
//
// Usage:
// The input stream carries one ASCII character per transfer in s_axis_tdata, with
// s_axis_tlast high on the final character of an address string. For every
// string the block returns one result transfer on the output stream:
// 0 for neither, 1 for a valid IPv4 address, 2 for a full-form IPv6 address (eight groups, no ::).
// Characters without tlast produce no output.
// Throughput is one character per cycle while the input is not stalled as
// described below. The parse state is updated at the edge that accepts a
// character; the result is registered at the edge that accepts the final
// character and is shown on m_axis_tvalid in the next cycle.
// If the receiver stalls while a result is waiting, s_axis_tready stays high
// until a further final character would overwrite it; then the input stalls
// until the result is taken. A result taken in the same cycle frees the register.
// Reset clears the parse state to the start of a new string and drops any
// pending result. After each result the state returns to that start.
`default_nettype none
`include "ip_address_text_classifier_unit_macros.svh"
module ip_address_text_classifier_unit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] character
  input  wire logic       s_axis_tlast,   // last
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [1:0] address_kind, [7:2] zero
);

  // Parse state.
  logic       dotted_possible, dotted_possible_next;
  logic       colon_possible, colon_possible_next;
  logic [8:0] group_value, group_value_next;
  logic [2:0] group_digit_count, group_digit_count_next;
  logic       group_leading_zero, group_leading_zero_next;
  logic [2:0] dot_count, dot_count_next;
  logic [3:0] colon_count, colon_count_next;

  // Result register.
  logic [1:0] address_kind, address_kind_next;

  logic       in_xfer;
  logic       is_digit, is_hex_letter, is_dot, is_colon;
  logic [3:0] digit;
  logic [11:0] scaled;
  logic [2:0] count_inc;
  logic       v4_cur_ok, v6_cur_ok, v4_next_ok, v6_next_ok;

  // Input may be taken unless a final character would overwrite a stalled result.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready || !s_axis_tlast;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Character classes.
  assign is_digit = (s_axis_tdata >= ipatc_pkg::CHAR_ZERO) &&
                    (s_axis_tdata <= ipatc_pkg::CHAR_NINE);
  assign is_hex_letter = ((s_axis_tdata >= ipatc_pkg::CHAR_LOWER_A) &&
                          (s_axis_tdata <= ipatc_pkg::CHAR_LOWER_F)) ||
                         ((s_axis_tdata >= ipatc_pkg::CHAR_UPPER_A) &&
                          (s_axis_tdata <= ipatc_pkg::CHAR_UPPER_F));
  assign is_dot   = (s_axis_tdata == ipatc_pkg::CHAR_DOT);
  assign is_colon = (s_axis_tdata == ipatc_pkg::CHAR_COLON);
  assign digit    = s_axis_tdata[3:0];

  // Decimal accumulate: value * 10 + digit as (value << 3) + (value << 1) + digit.
  assign scaled = {group_value, 3'b000} + {2'b00, group_value, 1'b0} + {8'd0, digit};

  // Saturating character count.
  assign count_inc = (group_digit_count < ipatc_pkg::COUNT_SAT) ?
                     group_digit_count + 3'd1 : group_digit_count;

  // Group checks on the group that a separator closes.
  assign v4_cur_ok = (group_digit_count != 3'd0) &&
                     (group_value <= ipatc_pkg::VALUE_MAX) &&
                     !(group_leading_zero && (group_digit_count > 3'd1));
  assign v6_cur_ok = (group_digit_count >= 3'd1) &&
                     (group_digit_count <= ipatc_pkg::V6_MAX_CHARS);

  // Next parse state for the character on the input.
  always_comb begin
    dotted_possible_next    = dotted_possible;
    colon_possible_next     = colon_possible;
    group_value_next        = group_value;
    group_digit_count_next  = group_digit_count;
    group_leading_zero_next = group_leading_zero;
    dot_count_next          = dot_count;
    colon_count_next        = colon_count;
    if (is_digit) begin
      if ((group_digit_count == 3'd0) && (digit == 4'd0)) begin
        group_leading_zero_next = 1'b1;
      end
      if (scaled > {3'b000, ipatc_pkg::VALUE_SAT}) begin
        group_value_next = ipatc_pkg::VALUE_SAT;
      end else begin
        group_value_next = scaled[8:0];
      end
      group_digit_count_next = count_inc;
    end else if (is_hex_letter) begin
      dotted_possible_next   = 1'b0;
      group_digit_count_next = count_inc;
    end else if (is_dot) begin
      colon_possible_next = 1'b0;
      if (!v4_cur_ok || (dot_count >= ipatc_pkg::V4_DOTS)) begin
        dotted_possible_next = 1'b0;
      end
      if (dot_count < ipatc_pkg::COUNT_SAT) begin
        dot_count_next = dot_count + 3'd1;
      end
      group_value_next        = 9'd0;
      group_digit_count_next  = 3'd0;
      group_leading_zero_next = 1'b0;
    end else if (is_colon) begin
      dotted_possible_next = 1'b0;
      if (!v6_cur_ok || (colon_count >= ipatc_pkg::V6_COLONS)) begin
        colon_possible_next = 1'b0;
      end
      if (colon_count < ipatc_pkg::COLON_SAT) begin
        colon_count_next = colon_count + 4'd1;
      end
      group_value_next        = 9'd0;
      group_digit_count_next  = 3'd0;
      group_leading_zero_next = 1'b0;
    end else begin
      dotted_possible_next = 1'b0;
      colon_possible_next  = 1'b0;
    end
  end

  // Final-group checks on the updated state.
  assign v4_next_ok = (group_digit_count_next != 3'd0) &&
                      (group_value_next <= ipatc_pkg::VALUE_MAX) &&
                      !(group_leading_zero_next && (group_digit_count_next > 3'd1));
  assign v6_next_ok = (group_digit_count_next >= 3'd1) &&
                      (group_digit_count_next <= ipatc_pkg::V6_MAX_CHARS);

  // Classification of a completed string.
  always_comb begin
    if (dotted_possible_next && (dot_count_next == ipatc_pkg::V4_DOTS) && v4_next_ok) begin
      address_kind_next = ipatc_pkg::KIND_V4;
    end else if (colon_possible_next && (colon_count_next == ipatc_pkg::V6_COLONS) &&
                 v6_next_ok) begin
      address_kind_next = ipatc_pkg::KIND_V6;
    end else begin
      address_kind_next = ipatc_pkg::KIND_NEITHER;
    end
  end

  // Parse state registers; a final character returns them to the start state.
  always_ff @(posedge clk) begin
    if (rst) begin
      dotted_possible    <= 1'b1;
      colon_possible     <= 1'b1;
      group_value        <= 9'd0;
      group_digit_count  <= 3'd0;
      group_leading_zero <= 1'b0;
      dot_count          <= 3'd0;
      colon_count        <= 4'd0;
    end else if (in_xfer) begin
      if (s_axis_tlast) begin
        dotted_possible    <= 1'b1;
        colon_possible     <= 1'b1;
        group_value        <= 9'd0;
        group_digit_count  <= 3'd0;
        group_leading_zero <= 1'b0;
        dot_count          <= 3'd0;
        colon_count        <= 4'd0;
      end else begin
        dotted_possible    <= dotted_possible_next;
        colon_possible     <= colon_possible_next;
        group_value        <= group_value_next;
        group_digit_count  <= group_digit_count_next;
        group_leading_zero <= group_leading_zero_next;
        dot_count          <= dot_count_next;
        colon_count        <= colon_count_next;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (in_xfer && s_axis_tlast) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (in_xfer && s_axis_tlast) begin
      address_kind <= address_kind_next;
    end
  end

  assign m_axis_tdata = {6'd0, address_kind};

  // A final character always produces a result in the next cycle.
  `IPATC_ASSERT_NEXT(a_last_gives_result, clk, rst, in_xfer && s_axis_tlast, m_axis_tvalid)
  // A non-final character after the result register is freed produces nothing.
  `IPATC_ASSERT_NEXT(a_no_spurious_result, clk, rst,
    in_xfer && !s_axis_tlast && (!m_axis_tvalid || m_axis_tready), !m_axis_tvalid)
  // The result code is never the unused encoding.
  `IPATC_ASSERT_IMPLIES(a_kind_legal, clk, rst, m_axis_tvalid, address_kind != 2'd3)
  // After a final character the parse state is back at the start of a string.
  `IPATC_ASSERT_NEXT(a_state_restarts, clk, rst, in_xfer && s_axis_tlast,
    dotted_possible && colon_possible && (dot_count == 3'd0) &&
    (colon_count == 4'd0) && (group_digit_count == 3'd0))
  // Both formats cannot stay possible once a separator has been seen.
  `IPATC_ASSERT_IMPLIES(a_formats_exclusive, clk, rst,
    (dot_count != 3'd0) || (colon_count != 4'd0), !(dotted_possible && colon_possible))

endmodule
`default_nettype wire
